// ===== sv/shc_pkg.sv =====
`default_nettype none

package shc_pkg;

  // Initial words of the two running hashes for each mode.
  localparam logic [31:0] TUPLE_INIT1 = 32'd5003;
  localparam logic [31:0] TUPLE_INIT2 = 32'd600073;
  localparam logic [31:0] SET_INIT1   = 32'd123077;
  localparam logic [31:0] SET_INIT2   = 32'd50236073;

  localparam logic [31:0] TUPLE_EMPTY = TUPLE_INIT1 ^ TUPLE_INIT2;
  localparam logic [31:0] SET_EMPTY   = SET_INIT1 ^ SET_INIT2;

  // Moduli used by the tuple rules and their 2^32 reciprocals.
  localparam logic [31:0] MOD_ODD  = 32'd2600057;
  localparam logic [31:0] MOD_EVEN = 32'd32600081;
  localparam logic [11:0] RECIP_ODD  = 12'((64'd1 << 32) / 64'd2600057);
  localparam logic [11:0] RECIP_EVEN = 12'((64'd1 << 32) / 64'd32600081);

  // Mode codes.
  localparam logic MODE_TUPLE = 1'b0;
  localparam logic MODE_SET   = 1'b1;

  typedef struct packed {
    logic [31:0] element_hash;
    logic        present;
    logic        set_kind;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] h1;
    logic [31:0] h2;
  } mix_t;

  // Remainder of x by a constant d, given m = floor(2^32 / d). The quotient
  // estimate is low by at most one, so one conditional subtract corrects it.
  function automatic logic [31:0] mod_const(input logic [31:0] x, input logic [31:0] d,
                                            input logic [11:0] m);
    logic [43:0] prod;
    logic [11:0] q;
    logic [31:0] r;
    prod = 44'(x) * 44'(m);
    q    = prod[43:32];
    r    = x - 32'(32'(q) * d);
    if (r >= d) begin
      r = r - d;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/shc_in_if.sv =====
`default_nettype none

interface shc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_hash;
  logic        present;
  logic        set_kind;
  logic        last;

  modport source(output valid, output element_hash, output present, output set_kind,
                 output last, input ready);
  modport sink(input valid, input element_hash, input present, input set_kind,
               input last, output ready);
endinterface

`default_nettype wire

// ===== sv/shc_out_if.sv =====
`default_nettype none

interface shc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sequence_hash;
  logic [15:0] element_count;
  logic        overflow;

  modport source(output valid, output sequence_hash, output element_count,
                 output overflow, input ready);
  modport sink(input valid, input sequence_hash, input element_count,
               input overflow, output ready);
endinterface

`default_nettype wire

// ===== sv/sequence_hash_combiner.sv =====
// A request is registered in the input stage, a closing request's result in the result
// stage. One request per cycle unless stalled; the mixing step updates the run state.
// A request with last set stalls only while an earlier result is still waiting.
// Reset (rst, synchronous, active high) clears the run and empties both stages.
`default_nettype none

module sequence_hash_combiner
  import shc_pkg::*;
#(
  parameter longint unsigned MAX_ELEMENTS = 65535
) (
  input wire logic  clk,
  input wire logic  rst,
  shc_in_if.sink    items,
  shc_out_if.source results
);

  // The element index saturates at MAX_ELEMENTS, so it needs just enough bits for that.
  localparam int IDX_W = $clog2(MAX_ELEMENTS + 64'd1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_ELEMENTS);

  // Input stage: one registered request.
  logic  s1_valid;
  item_t s1_item;

  // Run state, carried from one element to the next.
  logic             run_started;
  logic             run_mode;
  logic             run_ovf;
  logic [IDX_W-1:0] run_idx;
  mix_t             run_mix;

  // Result stage: holds the final mix words; the fixup is applied on the way out.
  logic        out_valid;
  logic        out_mode;
  logic        out_empty;
  logic        out_ovf;
  logic [15:0] out_count;
  mix_t        out_mix;

  logic advance;
  logic accept;

  // A request leaves the input stage unless it closes a run and the result stage
  // is still occupied by a result nobody has taken.
  assign advance = s1_valid && (!s1_item.last || !out_valid || results.ready);
  assign items.ready = !s1_valid || advance;
  assign accept = items.valid && items.ready;

  // Run state as seen by the registered request: a fresh run takes its mode
  // from this request and starts from that mode's initial words.
  logic             base_mode;
  logic             base_ovf;
  logic [IDX_W-1:0] base_idx;
  mix_t             base_mix;
  mix_t             mixed;

  always_comb begin
    if (!run_started) begin
      base_mode = s1_item.set_kind;
      base_ovf  = 1'b0;
      base_idx  = '0;
      base_mix  = s1_item.set_kind ? '{h1: SET_INIT1, h2: SET_INIT2}
                                   : '{h1: TUPLE_INIT1, h2: TUPLE_INIT2};
    end else begin
      base_mode = run_mode;
      base_ovf  = run_ovf;
      base_idx  = run_idx;
      base_mix  = run_mix;
    end
  end

  shc_mix_core u_mix (
    .mode (base_mode),
    .cur  (base_mix),
    .ix   (32'(base_idx)),
    .c    (s1_item.element_hash),
    .nxt  (mixed)
  );

  // Apply the element: absent elements leave the state alone, and once the
  // index is saturated a present element only raises the overflow flag.
  logic             upd_ovf;
  logic [IDX_W-1:0] upd_idx;
  mix_t             upd_mix;

  always_comb begin
    upd_ovf = base_ovf;
    upd_idx = base_idx;
    upd_mix = base_mix;
    if (s1_item.present) begin
      if (base_idx >= IDX_MAX) begin
        upd_ovf = 1'b1;
      end else begin
        upd_idx = IDX_W'(base_idx + 1'b1);
        upd_mix = mixed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      run_started <= 1'b0;
      run_mode    <= MODE_TUPLE;
      run_ovf     <= 1'b0;
      run_idx     <= '0;
      run_mix     <= '{h1: TUPLE_INIT1, h2: TUPLE_INIT2};
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_item  <= '{element_hash: items.element_hash, present: items.present,
                      set_kind: items.set_kind, last: items.last};
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (out_valid && results.ready && !(advance && s1_item.last)) begin
        out_valid <= 1'b0;
      end

      if (advance) begin
        if (s1_item.last) begin
          // Close the run: capture its result and go back to the reset state.
          out_valid   <= 1'b1;
          out_mode    <= base_mode;
          out_empty   <= (upd_idx == '0);
          out_ovf     <= upd_ovf;
          out_count   <= 16'(32'(upd_idx));
          out_mix     <= upd_mix;
          run_started <= 1'b0;
          run_mode    <= MODE_TUPLE;
          run_ovf     <= 1'b0;
          run_idx     <= '0;
          run_mix     <= '{h1: TUPLE_INIT1, h2: TUPLE_INIT2};
        end else begin
          run_started <= 1'b1;
          run_mode    <= base_mode;
          run_ovf     <= upd_ovf;
          run_idx     <= upd_idx;
          run_mix     <= upd_mix;
        end
      end
    end
  end

  shc_finalize u_fin (
    .mode  (out_mode),
    .empty (out_empty),
    .fin   (out_mix),
    .count (out_count),
    .hash  (results.sequence_hash)
  );

  assign results.valid         = out_valid;
  assign results.element_count = out_count;
  assign results.overflow      = out_ovf;

  // The index never runs past its saturation value.
  a_idx_sat: assert property (@(posedge clk) disable iff (rst) run_idx <= IDX_MAX)
    else $error("element index beyond saturation");

  // Closing a run always returns the block to the start of a new run.
  a_run_close: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.last |=> !run_started && run_idx == '0 && !run_ovf)
    else $error("run state not cleared after last request");

  // Overflow can only be reported for a run that mixed elements.
  a_ovf_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ovf |-> !out_empty)
    else $error("overflow reported for an empty run");

  // The input side stalls only behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> s1_valid && s1_item.last && out_valid && !results.ready)
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire

// ===== sv/shc_mix_core.sv =====
`default_nettype none

module shc_mix_core
  import shc_pkg::*;
(
  input  wire logic        mode,
  input  wire mix_t        cur,
  input  wire logic [31:0] ix,
  input  wire logic [31:0] c,
  output mix_t             nxt
);

  logic [31:0] h1;
  logic [31:0] h2;
  logic [31:0] rem_odd;
  logic [31:0] rem_even;
  logic [31:0] weight;

  assign h1 = cur.h1;
  assign h2 = cur.h2;

  assign rem_odd  = mod_const(h2, MOD_ODD, RECIP_ODD);
  assign rem_even = mod_const(h1, MOD_EVEN, RECIP_EVEN);
  assign weight   = 32'(5'(c[3:0]) + 5'd1);

  always_comb begin
    nxt = cur;
    if (mode == MODE_TUPLE) begin
      if (ix[0]) begin
        nxt.h1 = (h1 * 32'd15017 + c) ^ (rem_odd + ix);
        nxt.h2 = (32'd3539 * h2 + 32'd3 * ix) ^ (32'd13 * c);
      end else begin
        nxt.h1 = (rem_even + 32'd11 * ix) ^ (32'd3 * c + 32'd17 * h2);
        nxt.h2 = (32'd11 * h2) ^ c;
      end
    end else begin
      if (!ix[0]) begin
        nxt.h1 = (h1 * 32'd503 + c * 32'd17) ^ (h2 * 32'd7 + ix);
        nxt.h2 = h2 * 32'd2503 - c * 32'd31 + ix * weight;
      end else begin
        nxt.h1 = (c * 32'd157 + ix - 32'd3 * h1) ^ (32'd11 * h2);
        nxt.h2 = (h2 * 32'd163 + c) ^ (ix + {27'd0, h2[4:0]});
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/shc_finalize.sv =====
`default_nettype none

module shc_finalize
  import shc_pkg::*;
(
  input  wire logic        mode,
  input  wire logic        empty,
  input  wire mix_t        fin,
  input  wire logic [15:0] count,
  output logic [31:0]      hash
);

  logic [31:0] folded;
  logic [31:0] lo1;
  logic [31:0] lo2;

  assign folded = fin.h1 ^ fin.h2;
  assign lo1    = {16'd0, fin.h1[15:0]};
  assign lo2    = {16'd0, fin.h2[15:0]};

  // Empty runs give the mode constant; small folded values become a weighted sum of the low halves.
  always_comb begin
    if (empty) begin
      hash = (mode == MODE_SET) ? SET_EMPTY : TUPLE_EMPTY;
    end else if (mode == MODE_SET) begin
      hash = (folded < 32'd5)
           ? 32'd11 * lo1 + 32'd17 * lo2 + {24'd0, count[7:0]} + 32'd1
           : folded;
    end else begin
      hash = (folded < 32'd10) ? 32'd11 * lo1 + 32'd31 * lo2 + 32'd2 : folded;
    end
  end

endmodule

`default_nettype wire

// ===== dv/sequence_hash_combiner_test.sv =====
module sequence_hash_combiner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import shc_pkg::MODE_TUPLE;
  import shc_pkg::MODE_SET;

  // The block is checked at its default element limit. The runs sent here stay
  // well below it, so the count never saturates.
  localparam int unsigned MAX_ELEMENTS = 65535;

  // The slowest correct run has fewer than 1k requests, each after a random idle
  // gap, every result may wait out a random sink stall, and one result waits out
  // the long hold. The watchdog allows several times as long as all of that.
  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_CYCLES = 10;

  // Starting words of the two running hashes in each mode.
  localparam bit [31:0] TUPLE_SEED1 = 32'd5003;
  localparam bit [31:0] TUPLE_SEED2 = 32'd600073;
  localparam bit [31:0] SET_SEED1 = 32'd123077;
  localparam bit [31:0] SET_SEED2 = 32'd50236073;
  localparam bit [31:0] EMPTY_TUPLE = TUPLE_SEED1 ^ TUPLE_SEED2;
  localparam bit [31:0] EMPTY_SET = SET_SEED1 ^ SET_SEED2;

  // Final results below these values get the small-value fixup.
  localparam bit [31:0] TUPLE_FIXUP_BOUND = 32'd10;
  localparam bit [31:0] SET_FIXUP_BOUND = 32'd5;

  // Running state of one sequence, as the block keeps it.
  typedef struct packed {
    bit [31:0] h1;
    bit [31:0] h2;
    bit [15:0] count;
    bit        mode;
    bit        started;
    bit        ovf;
  } run_t;

  typedef struct packed {
    bit [31:0] sequence_hash;
    bit [15:0] element_count;
    bit        overflow;
  } result_t;

  // One row of the directed table. A row with seek set stands for a whole
  // run whose element hashes are searched for at run time so that the final
  // hash lands in the small-value fixup. A pinned row carries a result that is
  // typed in and used in place of the computed one.
  typedef struct packed {
    bit [31:0] hash;
    bit        present;
    bit        kind;
    bit        last;
    bit        seek;
    bit        pinned;
    result_t   want;
  } row_t;

  localparam run_t IDLE_RUN = '{TUPLE_SEED1, TUPLE_SEED2, 16'd0, MODE_TUPLE, 1'b0, 1'b0};
  localparam result_t NO_RESULT = '0;

  localparam int unsigned DIRECTED_COUNT = 20;
  localparam row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    // Empty runs straight out of reset, one in each mode.
    '{32'h0000_0000, 1'b0, MODE_TUPLE, 1'b1, 1'b0, 1'b1, '{EMPTY_TUPLE, 16'd0, 1'b0}},
    '{32'hffff_ffff, 1'b0, MODE_SET, 1'b1, 1'b0, 1'b1, '{EMPTY_SET, 16'd0, 1'b0}},
    // An empty set run made of null requests; the mode on the later
    // requests is ignored, so the answer stays the set constant.
    '{32'hdead_beef, 1'b0, MODE_SET, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{32'h0000_0000, 1'b0, MODE_TUPLE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{32'h1234_5678, 1'b0, MODE_TUPLE, 1'b1, 1'b0, 1'b1, '{EMPTY_SET, 16'd0, 1'b0}},
    // Single-element tuple runs with the largest hash and with a zero hash.
    '{32'hffff_ffff, 1'b1, MODE_TUPLE, 1'b1, 1'b0, 1'b0, NO_RESULT},
    '{32'h0000_0000, 1'b1, MODE_TUPLE, 1'b1, 1'b0, 1'b0, NO_RESULT},
    // Tuple run with a null in the middle (renumbering) and a null last item.
    '{32'h0000_0001, 1'b1, MODE_TUPLE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{32'h5555_5555, 1'b0, MODE_SET, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{32'haaaa_aaaa, 1'b1, MODE_SET, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{32'h8000_0000, 1'b1, MODE_TUPLE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{32'h7fff_ffff, 1'b0, MODE_TUPLE, 1'b1, 1'b0, 1'b0, NO_RESULT},
    // Set run covering both index parities, a zero hash and a null.
    '{32'h0000_0000, 1'b1, MODE_SET, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{32'hffff_ffff, 1'b1, MODE_TUPLE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{32'h5555_5555, 1'b0, MODE_SET, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{32'haaaa_aaaa, 1'b1, MODE_SET, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{32'h0000_0001, 1'b1, MODE_SET, 1'b1, 1'b0, 1'b0, NO_RESULT},
    // Runs that end in the small-value fixup, one per mode.
    '{32'h0000_0000, 1'b1, MODE_TUPLE, 1'b1, 1'b1, 1'b0, NO_RESULT},
    '{32'h0000_0000, 1'b1, MODE_SET, 1'b1, 1'b1, 1'b0, NO_RESULT},
    // Single-element set run with the largest hash.
    '{32'hffff_ffff, 1'b1, MODE_SET, 1'b1, 1'b0, 1'b0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst;

  shc_in_if items ();
  shc_out_if results ();

  sequence_hash_combiner #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results)
  );

  always #5 clk = ~clk;

  // Run state of the sequence being folded, and the results still owed by the
  // block, oldest first.
  run_t run_sum = IDLE_RUN;
  result_t owed_results[$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;

  // Flags from the request driver to the result sink. calm turns idling off
  // on both sides; hold_pending asks the sink for one long hold.
  bit calm = 1'b0;
  bit hold_pending = 1'b0;

  // Typed-in result that travels alongside the request being offered.
  bit pin_on = 1'b0;
  result_t pin_result = '0;

  // Element hashes of a run planned to end in the small-value fixup.
  bit [31:0] fixup_run[$];

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // The first request of a sequence fixes the mode and loads its seed words.
  function automatic run_t open_run(input run_t r, input bit kind);
    if (!r.started) begin
      r.started = 1'b1;
      r.mode = kind;
      r.h1 = (kind == MODE_SET) ? SET_SEED1 : TUPLE_SEED1;
      r.h2 = (kind == MODE_SET) ? SET_SEED2 : TUPLE_SEED2;
      r.count = 16'd0;
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // Mix one present element into the running words. All arithmetic wraps at
  // 32 bits; the element index is the count of elements mixed so far.
  function automatic run_t mix_element(input run_t r, input bit [31:0] c);
    bit [31:0] a;
    bit [31:0] b;
    bit [31:0] ix;
    if (32'(r.count) >= MAX_ELEMENTS) begin
      // Saturated: the element is dropped and the run is marked.
      r.ovf = 1'b1;
      return r;
    end
    a = r.h1;
    b = r.h2;
    ix = {16'd0, r.count};
    if (r.mode == MODE_TUPLE) begin
      if (ix[0]) begin
        r.h1 = (a * 32'd15017 + c) ^ (b % 32'd2600057 + ix);
        r.h2 = (32'd3539 * b + 32'd3 * ix) ^ (32'd13 * c);
      end else begin
        r.h1 = (a % 32'd32600081 + 32'd11 * ix) ^ (32'd3 * c + 32'd17 * b);
        r.h2 = (32'd11 * b) ^ c;
      end
    end else begin
      if (!ix[0]) begin
        r.h1 = (a * 32'd503 + c * 32'd17) ^ (b * 32'd7 + ix);
        r.h2 = b * 32'd2503 - c * 32'd31 + ix * (32'd1 + {28'd0, c[3:0]});
      end else begin
        r.h1 = (c * 32'd157 + ix - 32'd3 * a) ^ (32'd11 * b);
        r.h2 = (b * 32'd163 + c) ^ (ix + {27'd0, b[4:0]});
      end
    end
    r.count = r.count + 16'd1;
    return r;
  endfunction

  // Final hash of a finished sequence: the mode's empty constant when nothing
  // was mixed, otherwise the folded words with the small-value fixup.
  function automatic result_t close_run(input run_t r);
    result_t o;
    bit [31:0] x;
    x = r.h1 ^ r.h2;
    if (r.count == 16'd0) begin
      x = (r.mode == MODE_SET) ? EMPTY_SET : EMPTY_TUPLE;
    end else if (r.mode == MODE_SET && x < SET_FIXUP_BOUND) begin
      x = 32'd11 * {16'd0, r.h1[15:0]} + 32'd17 * {16'd0, r.h2[15:0]}
          + {24'd0, r.count[7:0]} + 32'd1;
    end else if (r.mode == MODE_TUPLE && x < TUPLE_FIXUP_BOUND) begin
      x = 32'd11 * {16'd0, r.h1[15:0]} + 32'd31 * {16'd0, r.h2[15:0]} + 32'd2;
    end
    o.sequence_hash = x;
    o.element_count = r.count;
    o.overflow = r.ovf;
    return o;
  endfunction

  // Plan a run in the given mode whose last element brings h1 ^ h2 under the
  // fixup bound. Bit k of the folded words depends only on bits 0..k of the
  // last element, so the element is grown one bit at a time, keeping every
  // prefix whose low bits can still end below the bound. If no element works
  // after the seed words alone, random leading elements are tried.
  task automatic plan_fixup_run(input bit kind);
    run_t base;
    run_t t;
    bit [31:0] prefix[$];
    bit [31:0] cand[$];
    bit [31:0] grown[$];
    bit [31:0] mask;
    bit [31:0] bound;
    bit [31:0] c;
    bound = (kind == MODE_SET) ? SET_FIXUP_BOUND : TUPLE_FIXUP_BOUND;
    fixup_run = {};
    for (int attempt = 0; attempt < 64 && fixup_run.size() == 0; attempt++) begin
      base = open_run(IDLE_RUN, kind);
      prefix = {};
      repeat (attempt % 4) begin
        c = $urandom();
        prefix.push_back(c);
        base = mix_element(base, c);
      end
      cand = {32'd0};
      for (int k = 0; k < 32; k++) begin
        mask = (k == 31) ? 32'hffff_ffff : ((32'd1 << (k + 1)) - 32'd1);
        grown = {};
        foreach (cand[i]) begin
          for (int b = 0; b < 2; b++) begin
            c = cand[i] | (32'(b) << k);
            t = mix_element(base, c);
            if (((t.h1 ^ t.h2) & mask) < bound && grown.size() < 4096) begin
              grown.push_back(c);
            end
          end
        end
        cand = grown;
      end
      if (cand.size() != 0) begin
        fixup_run = prefix;
        fixup_run.push_back(cand[$urandom_range(0, cand.size() - 1)]);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input bit [31:0] got, input bit [31:0] want);
    $display("mismatch at cycle %0d: %s is %0h, expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Folds every accepted request into the run state and compares every
  // accepted result with the oldest owed one. Both happen in this one block,
  // so an expectation is always queued before the result that answers it.
  always @(posedge clk) begin : fold_and_compare
    result_t got;
    result_t want;
    if (rst) begin
      run_sum = IDLE_RUN;
    end else begin
      if (items.valid && items.ready) begin
        run_sum = open_run(run_sum, items.set_kind);
        if (items.present) begin
          run_sum = mix_element(run_sum, items.element_hash);
        end
        if (items.last) begin
          owed_results.push_back(pin_on ? pin_result : close_run(run_sum));
          run_sum = IDLE_RUN;
        end
      end
      if (results.valid && results.ready) begin
        got = '{results.sequence_hash, results.element_count, results.overflow};
        if (owed_results.size() == 0) begin
          report_mismatch("result with no request pending", got.sequence_hash, 32'd0);
        end else begin
          want = owed_results.pop_front();
          if (got.sequence_hash != want.sequence_hash) begin
            report_mismatch("sequence_hash", got.sequence_hash, want.sequence_hash);
          end
          if (got.element_count != want.element_count) begin
            report_mismatch("element_count", 32'(got.element_count), 32'(want.element_count));
          end
          if (got.overflow != want.overflow) begin
            report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
          end
        end
      end
    end
  end

  // Watchdog: a run that hangs or loses results ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink
  // ---------------------------------------------------------------------------

  // Before each result the sink draws a random stall, none while calm is set. Once,
  // when asked, it holds ready low for a long stretch so that the block backs up and
  // stalls its request side.
  initial begin : result_sink
    int unsigned stall;
    bit hold_served;
    hold_served = 1'b0;
    results.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_pending && !hold_served) begin
        hold_served = 1'b1;
        results.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = calm ? 0 : $urandom_range(0, 10);
        if (stall != 0) begin
          results.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Offer one request and return at the edge where it is taken. The idle gap
  // before it is drawn per request; with no gap valid simply stays high.
  task automatic send_request(input bit [31:0] hash, input bit present, input bit kind,
                              input bit last, input bit pinned, input result_t want);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items.valid <= 1'b1;
    items.element_hash <= hash;
    items.present <= present;
    items.set_kind <= kind;
    items.last <= last;
    pin_on <= pinned;
    pin_result <= want;
    do @(posedge clk); while (!items.ready);
    requests_sent++;
  endtask

  // Hash values lean toward zero and all ones; the rest are uniform.
  function automatic bit [31:0] pick_hash();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Whole sequences with random content until about goal requests have gone.
  // Most runs are short so that results come often; some are longer, about a
  // fifth of the requests are nulls, and the mode bit is random on requests
  // after the first, where the block must ignore it.
  task automatic random_runs(input int unsigned goal);
    int unsigned target;
    int unsigned len;
    bit kind;
    target = requests_sent + goal;
    while (requests_sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
      kind = 1'($urandom_range(0, 1));
      for (int unsigned n = 1; n <= len; n++) begin
        send_request(pick_hash(), $urandom_range(0, 4) != 0,
                     (n == 1) ? kind : 1'($urandom_range(0, 1)), n == len, 1'b0, NO_RESULT);
      end
    end
  endtask

  initial begin : drive_requests
    row_t row;
    rst <= 1'b1;
    items.valid <= 1'b0;
    items.element_hash <= '0;
    items.present <= 1'b0;
    items.set_kind <= 1'b0;
    items.last <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Fixup rows expand into a planned run; every fixup run
    // starts a fresh sequence because the row before it is a last request.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.seek) begin
        plan_fixup_run(row.kind);
        foreach (fixup_run[j]) begin
          send_request(fixup_run[j], 1'b1, row.kind, j == fixup_run.size() - 1, 1'b0,
                       NO_RESULT);
        end
      end else begin
        send_request(row.hash, row.present, row.kind, row.last, row.pinned, row.want);
      end
    end

    // Random traffic with idling on both sides.
    random_runs(220);

    // A stretch at full rate on both sides.
    calm <= 1'b1;
    random_runs(100);

    // Back pressure: the sink holds off for a long time while requests keep
    // coming at full rate, so the block fills and refuses requests.
    hold_pending <= 1'b1;
    random_runs(150);

    calm <= 1'b0;
    random_runs(220);
    random_runs(30);

    // Wait for every owed result, then DRAIN_CYCLES more for strays. Waiting on a clock
    // edge first lets the checker queue the result of the final request.
    items.valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/shc_pkg.sv
sv/shc_in_if.sv
sv/shc_out_if.sv
sv/shc_mix_core.sv
sv/shc_finalize.sv
sv/sequence_hash_combiner.sv
dv/sequence_hash_combiner_test.sv
